>>> design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int ADDR_W = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;
  localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [DATA_W-1:0] MISS_VALUE   = 32'hFFFF_FFFF;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } lkv_state_e;

  typedef struct packed {
    logic cmp_en;
    logic apply_en;
  } lkv_ctrl_t;

endpackage : lkv_pkg

`default_nettype wire

>>> design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement,
// built as a chain of cells kept in recency order (slot 0 most recent).
// ----------------------------------------------------------------------------
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   in       | in_valid_i / in_stall_o   | func_i, key_i, value_i
//   out      | out_valid_o / out_stall_i | hit_o, read_value_o, evicted_o,
//            |                           | evicted_key_o
//   config   | psel/penable/pwrite       | paddr, pwdata, prdata (capacity)
//
// Each word sees accept, key compare in every cell, then shift of the chain on
// a hit or put, and load of the output register; the next word is taken after.
// The apply cycle waits while the output register holds an untaken word.
// Reset clears all valid bits and occupancy and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     func_i,
  input  wire logic signed [DATA_W-1:0] key_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          hit_o,
  output logic signed [DATA_W-1:0]      read_value_o,
  output logic                          evicted_o,
  output logic signed [DATA_W-1:0]      evicted_key_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  lkv_state_e state_q, state_d;
  lkv_ctrl_t  ctrl;
  logic       fire;

  logic [CAP_W-1:0]  cap_q;
  logic [OCC_W-1:0]  occ_q, occ_d;

  logic              req_func_q;
  logic [DATA_W-1:0] req_key_q;
  logic [DATA_W-1:0] req_value_q;

  logic              out_valid_q;
  logic              hit_q, evicted_q;
  logic [DATA_W-1:0] read_value_q, evicted_key_q;

  logic [DATA_W-1:0] chain_key   [0:MAX_ENTRIES];
  logic [DATA_W-1:0] chain_value [0:MAX_ENTRIES];
  logic              chain_valid [0:MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match;
  logic [DATA_W-1:0] cell_sel_value [0:MAX_ENTRIES-1];
  logic [DATA_W-1:0] cell_sel_key   [0:MAX_ENTRIES-1];

  logic [DATA_W-1:0] sel_value, sel_key;
  logic [OCC_W-1:0]  match_idx, tail, lim;
  logic [CW-1:0]     eff_cap;
  logic              hit, need_evict, is_put;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_CAPACITY)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_CAPACITY) begin
      prdata = 32'(cap_q);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: state_d = ST_APPLY;
      ST_APPLY: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    ctrl.cmp_en   = (state_q == ST_MATCH);
    fire          = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);
    ctrl.apply_en = fire && (hit || is_put);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_func_q  <= func_i;
      req_key_q   <= key_i;
      req_value_q <= value_i;
    end
  end

  // cell chain
  assign tail = occ_q - OCC_W'(1);

  assign chain_key[0]   = req_key_q;
  assign chain_value[0] = is_put ? req_value_q : sel_value;
  assign chain_valid[0] = 1'b1;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .IDX   (i),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cmp_key_i    (req_key_q),
      .tail_i       (tail),
      .lim_i        (lim),
      .prev_key_i   (chain_key[i]),
      .prev_value_i (chain_value[i]),
      .prev_valid_i (chain_valid[i]),
      .key_o        (chain_key[i+1]),
      .value_o      (chain_value[i+1]),
      .valid_o      (chain_valid[i+1]),
      .match_o      (match[i]),
      .sel_value_o  (cell_sel_value[i]),
      .sel_key_o    (cell_sel_key[i])
    );
  end

  always_comb begin
    sel_value = '0;
    sel_key   = '0;
    match_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sel_value = sel_value | cell_sel_value[i];
      sel_key   = sel_key | cell_sel_key[i];
      match_idx = match_idx | (OCC_W'(i) & {OCC_W{match[i]}});
    end
  end

  always_comb begin
    eff_cap = CW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_q) > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end
  end

  assign is_put     = (req_func_q == FUNC_PUT);
  assign hit        = |match;
  assign need_evict = (CW'(occ_q) >= eff_cap);

  always_comb begin
    priority if (hit) begin
      lim = match_idx;
    end else if (need_evict) begin
      lim = tail;
    end else begin
      lim = occ_q;
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (fire && is_put && !hit && !need_evict) begin
      occ_d = occ_q + OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_q     <= hit;
      evicted_q <= is_put && !hit && need_evict;
      if (is_put) begin
        read_value_q <= '0;
      end else if (hit) begin
        read_value_q <= sel_value;
      end else begin
        read_value_q <= MISS_VALUE;
      end
      evicted_key_q <= (is_put && !hit && need_evict) ? sel_key : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign read_value_o  = read_value_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;

endmodule : lru_key_value_cache

`default_nettype wire

>>> design/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// One recency slot of the chain: holds a key, a value and a valid bit,
// flags a key match and the tail slot, and loads its neighbor's word on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell
  import lkv_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int OCC_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lkv_ctrl_t         ctrl_i,
  input  wire logic [DATA_W-1:0] cmp_key_i,
  input  wire logic [OCC_W-1:0]  tail_i,
  input  wire logic [OCC_W-1:0]  lim_i,
  input  wire logic [DATA_W-1:0] prev_key_i,
  input  wire logic [DATA_W-1:0] prev_value_i,
  input  wire logic              prev_valid_i,
  output logic [DATA_W-1:0]      key_o,
  output logic [DATA_W-1:0]      value_o,
  output logic                   valid_o,
  output logic                   match_o,
  output logic [DATA_W-1:0]      sel_value_o,
  output logic [DATA_W-1:0]      sel_key_o
);

  localparam logic [OCC_W-1:0] IDX_C = OCC_W'(IDX);

  logic [DATA_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic              valid_q, valid_d;
  logic              match_q, match_d;
  logic              tail_q, tail_d;
  logic              shift;

  assign shift = ctrl_i.apply_en && (IDX_C <= lim_i);

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    valid_d = valid_q;
    match_d = match_q;
    tail_d  = tail_q;
    if (ctrl_i.cmp_en) begin
      match_d = valid_q && (key_q == cmp_key_i);
      tail_d  = (IDX_C == tail_i);
    end
    if (shift) begin
      key_d   = prev_key_i;
      value_d = prev_value_i;
      valid_d = prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      tail_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
      tail_q  <= tail_d;
    end
  end

  assign key_o       = key_q;
  assign value_o     = value_q;
  assign valid_o     = valid_q;
  assign match_o     = match_q;
  assign sel_value_o = value_q & {DATA_W{match_q}};
  assign sel_key_o   = key_q & {DATA_W{tail_q}};

endmodule : lkv_cell

`default_nettype wire

>>> design/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_assertions
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_assertions
  import lkv_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              hit_o,
  input wire logic [DATA_W-1:0] read_value_o,
  input wire logic              evicted_o,
  input wire logic [DATA_W-1:0] evicted_key_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_value_o)
      && $stable(evicted_key_o))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous word in flight");

  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !hit_o && (read_value_o == '0))
    else $error("eviction reported on a hit or a get");

  a_miss_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o && (read_value_o != '0) |->
      (read_value_o == MISS_VALUE) && !evicted_o && (evicted_key_o == '0))
    else $error("bad get miss word");

endmodule : lkv_assertions

bind lru_key_value_cache lkv_assertions u_lkv_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .hit_o         (hit_o),
  .read_value_o  (read_value_o),
  .evicted_o     (evicted_o),
  .evicted_key_o (evicted_key_o)
);

`default_nettype wire
